// ===== rtl/core/iorb_pkg.sv =====
// Shared types and constants for the in-order release buffer.
package iorb_pkg;

    localparam int unsigned SLOT_W   = 7;
    localparam int unsigned IN_W     = 64;
    localparam int unsigned MAX_RUN  = 64;
    localparam int unsigned CNT_W    = 7;
    localparam logic [SLOT_W-1:0] LEN_RESET = 7'd64;
    localparam int unsigned MAX_SLOT = 127;

    typedef struct packed {
        logic              err;
        logic [SLOT_W-1:0] slot;
    } iorb_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_LOAD = 3'b100
    } iorb_state_t;

endpackage

// ===== rtl/core/in_order_release_buffer.sv =====
// Top level of the in-order release buffer: config register, front end, queue, back end.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, slot_id, data          request in
//   output    out_valid/out_ready, out_data,            request out
//             out_position, last, error
//   config    cfg_write_en, cfg_write_data              write only
//
// An insert does a slot write (IDLE) and a pointer check (SCAN), then releases slots
// from LOAD; an out-of-range request is answered from IDLE. The slot memory's single
// read port sets the release rate of one slot per cycle while out_ready is high.
// Reset clears the valid bits and the pointer at once; no clearing pass.
// A two-entry queue lets requests be taken while the back end drains or waits
// on out_ready.
module in_order_release_buffer #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [iorb_pkg::SLOT_W-1:0] cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [iorb_pkg::SLOT_W-1:0] slot_id,
    input  logic [iorb_pkg::IN_W-1:0]   data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [iorb_pkg::IN_W-1:0]   out_data,
    output logic [iorb_pkg::SLOT_W-1:0] out_position,
    output logic                        last,
    output logic                        error
);
    import iorb_pkg::*;

    localparam int unsigned SLOTS = (DEPTH < MAX_SLOT) ? DEPTH : MAX_SLOT;
    localparam int unsigned PW    = $clog2(SLOTS + 1);
    localparam int unsigned QW    = $bits(iorb_cmd_t) + DATA_WIDTH;

    logic [SLOT_W-1:0]     stream_length_reg;
    logic [PW-1:0]         len;
    logic                  push;
    iorb_cmd_t             push_cmd;
    logic [DATA_WIDTH-1:0] push_data;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_head;
    iorb_cmd_t             q_cmd;
    logic [DATA_WIDTH-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            stream_length_reg <= cfg_write_data;
        end
    end

    assign len = (stream_length_reg > SLOT_W'(SLOTS)) ? PW'(SLOTS) : PW'(stream_length_reg);

    iorb_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .slot_id   (slot_id),
        .data      (data),
        .len       (len),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_data (push_data)
    );

    iorb_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_data}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign q_cmd  = q_head[QW-1:DATA_WIDTH];
    assign q_data = q_head[DATA_WIDTH-1:0];

    iorb_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .len          (len),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .out_position (out_position),
        .last         (last),
        .error        (error)
    );

endmodule

// ===== rtl/core/iorb_front.sv =====
// Front end: accepts requests, range-checks the slot and hands a command to the queue.
module iorb_front #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [iorb_pkg::SLOT_W-1:0]           slot_id,
    input  logic [iorb_pkg::IN_W-1:0]             data,
    input  logic [$clog2(((DEPTH < iorb_pkg::MAX_SLOT) ? DEPTH : iorb_pkg::MAX_SLOT) + 1)-1:0] len,
    input  logic                                  q_full,
    output logic                                  push,
    output iorb_pkg::iorb_cmd_t                   push_cmd,
    output logic [DATA_WIDTH-1:0]                 push_data
);
    import iorb_pkg::*;

    logic [SLOT_W-1:0] len_ext;

    assign len_ext  = SLOT_W'(len);
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_cmd.slot = slot_id;
        push_cmd.err  = (slot_id == '0) || (slot_id > len_ext);
    end

    assign push_data = data[DATA_WIDTH-1:0];

endmodule

// ===== rtl/core/iorb_queue.sv =====
// Two-entry command queue between front and back end.
module iorb_queue #(
    parameter int unsigned W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] head
);
    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/iorb_back.sv =====
// Back end: slot memory, valid bits, release pointer and output register.
module iorb_back #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  iorb_pkg::iorb_cmd_t                   q_cmd,
    input  logic [DATA_WIDTH-1:0]                 q_data,
    output logic                                  q_pop,
    input  logic [$clog2(((DEPTH < iorb_pkg::MAX_SLOT) ? DEPTH : iorb_pkg::MAX_SLOT) + 1)-1:0] len,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [iorb_pkg::IN_W-1:0]             out_data,
    output logic [iorb_pkg::SLOT_W-1:0]           out_position,
    output logic                                  last,
    output logic                                  error
);
    import iorb_pkg::*;

    localparam int unsigned SLOTS = (DEPTH < MAX_SLOT) ? DEPTH : MAX_SLOT;
    localparam int unsigned PW    = $clog2(SLOTS + 1);
    localparam int unsigned IW    = $clog2(SLOTS);

    logic [DATA_WIDTH-1:0] mem [SLOTS];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [PW-1:0]         ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  pend_last_reg;
    logic                  pend_last_next;
    iorb_state_t           state_reg;
    iorb_state_t           state_next;

    logic                  out_valid_reg;
    logic [IN_W-1:0]       out_data_reg;
    logic [SLOT_W-1:0]     out_position_reg;
    logic                  last_reg;
    logic                  error_reg;

    logic                  out_free;
    logic                  wr_en;
    logic                  rd_en;
    logic                  load_out;
    logic                  load_err;
    logic [IW-1:0]         wr_idx;
    logic [PW:0]           len_ext;
    logic [PW:0]           cur_ptr;
    logic [PW:0]           issue_ptr;
    logic [PW:0]           check_ptr;
    logic [CNT_W-1:0]      issue_cnt;
    logic                  cur_ok;
    logic                  next_ok;

    assign out_free  = !out_valid_reg || out_ready;
    assign wr_idx    = IW'(q_cmd.slot - SLOT_W'(1));
    assign len_ext   = {1'b0, len};
    assign cur_ptr   = {1'b0, ptr_reg};
    assign issue_ptr = (state_reg == ST_SCAN) ? cur_ptr : cur_ptr + (PW+1)'(1);
    assign issue_cnt = (state_reg == ST_SCAN) ? '0 : count_reg + CNT_W'(1);
    assign check_ptr = issue_ptr + (PW+1)'(1);
    assign cur_ok    = (cur_ptr < len_ext) && valid_reg[cur_ptr[IW-1:0]];
    assign next_ok   = (check_ptr < len_ext) && valid_reg[check_ptr[IW-1:0]]
                       && (issue_cnt < CNT_W'(MAX_RUN - 1));

    always_comb
    begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        load_out       = 1'b0;
        load_err       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (!q_cmd.err || out_free))
                begin
                    q_pop = 1'b1;
                    if (q_cmd.err)
                    begin
                        load_err = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cur_ok)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        pend_last_next = rd_en ? !next_ok : pend_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_last_reg <= pend_last_next;
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
                count_reg         <= '0;
            end
            if (load_out)
            begin
                ptr_reg   <= ptr_reg + PW'(1);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (load_out || load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= q_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_err)
        begin
            out_data_reg     <= '0;
            out_position_reg <= '0;
            last_reg         <= 1'b0;
            error_reg        <= 1'b1;
        end
        else if (load_out)
        begin
            out_data_reg     <= IN_W'(rd_data_reg);
            out_position_reg <= SLOT_W'(cur_ptr + (PW+1)'(1));
            last_reg         <= pend_last_reg;
            error_reg        <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign out_position = out_position_reg;
    assign last         = last_reg;
    assign error        = error_reg;

endmodule
